@@ hw/rtl/aesv_pkg.sv @@
// Shared types, constants and the sine table generator for the envelope sine voice.
package aesv_pkg;

  localparam int TIME_W    = 20;
  localparam int LEVEL_W   = 17;
  localparam int DIVD_W    = 37;
  localparam int QUOT_W    = 17;
  localparam int SAMPLE_W  = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 20;
  localparam int MID_DEPTH = 4;
  localparam int OUT_DEPTH = 32;

  localparam logic [LEVEL_W-1:0] ONE_Q16   = 17'h10000;
  localparam logic [14:0]        AMPLITUDE = 15'd30000;
  localparam longint unsigned    HALF_PI_Q30 = 64'd1686629713;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd4;

  typedef enum logic [2:0] {
    ENV_ATTACK,
    ENV_DECAY,
    ENV_SUSTAIN,
    ENV_RELEASE,
    ENV_ZERO
  } env_seg_t;

  // One classified item on its way from front to back.
  typedef struct packed {
    env_seg_t            seg;
    logic [DIVD_W-1:0]   dividend;
    logic [TIME_W-1:0]   divisor;
    logic [LEVEL_W-1:0]  sustain;
    logic [LEVEL_W-1:0]  mag;
    logic                neg;
  } mid_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [LEVEL_W-1:0]         level;
  } out_item_t;

  // Quarter-wave entry k in Q1.16 from a Q30 Taylor series.
  function automatic logic [LEVEL_W-1:0] quarter_sine(input longint unsigned k,
                                                      input int tbits);
    longint unsigned x;
    longint unsigned term;
    longint unsigned sum;
    longint unsigned r;
    bit sub;
    x = (k * HALF_PI_Q30) >> tbits;
    term = x;
    sum = x;
    sub = 1'b1;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      unique case (n)
        1: term = term / 6;
        2: term = term / 20;
        3: term = term / 42;
        4: term = term / 72;
        5: term = term / 110;
        6: term = term / 156;
        default: term = term / 210;
      endcase
      if (sub) sum = sum - term;
      else sum = sum + term;
      sub = !sub;
    end
    r = (sum + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[LEVEL_W-1:0];
  endfunction

endpackage

@@ hw/rtl/aesv_queue.sv @@
// Small first-in first-out queue with an occupancy count.
module aesv_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [WIDTH-1:0]           wdata,
  input  logic                       pop,
  output logic [WIDTH-1:0]           rdata,
  output logic                       empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [WIDTH-1:0] entries [0:DEPTH-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    used;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      used   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      if (pop) rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) used <= used + 1'b1;
      else if (pop && !push) used <= used - 1'b1;
    end
  end

  assign rdata = entries[rd_ptr];
  assign empty = (used == '0);
  assign count = used;
endmodule

@@ hw/rtl/aesv_front.sv @@
// Front end: configuration registers, envelope segment decode, phase and sine lookup.
module aesv_front #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [aesv_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aesv_pkg::CFG_DAT_W-1:0]      cfg_data,
  input  logic                                in_valid,
  input  logic [31:0]                         phase_step,
  input  logic [31:0]                         sample_index,
  input  logic [aesv_pkg::TIME_W-1:0]         note_time,
  output logic                                out_valid,
  output aesv_pkg::mid_item_t                 out_item
);
  import aesv_pkg::*;

  localparam int N  = 1 << SINE_TABLE_BITS;
  localparam int AW = SINE_TABLE_BITS + 1;

  logic [TIME_W-1:0]  attack_len;
  logic [TIME_W-1:0]  decay_len;
  logic [TIME_W-1:0]  release_len;
  logic [TIME_W-1:0]  note_len;
  logic [LEVEL_W-1:0] sustain_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_len  <= 20'd441;
      decay_len   <= 20'd2205;
      release_len <= 20'd4410;
      note_len    <= 20'd22050;
      sustain_raw <= 17'd45875;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_len  <= cfg_data;
        CFG_DECAY:   decay_len   <= cfg_data;
        CFG_RELEASE: release_len <= cfg_data;
        CFG_NOTE:    note_len    <= cfg_data;
        CFG_SUSTAIN: sustain_raw <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Segment decode and dividend operands.
  logic [LEVEL_W-1:0] sustain;
  logic [TIME_W:0]    ad_end;
  logic [TIME_W:0]    t_plus_r;
  env_seg_t           seg;
  logic [LEVEL_W-1:0] mul_a;
  logic [TIME_W-1:0]  mul_b;
  logic [TIME_W-1:0]  divisor;

  assign sustain  = (sustain_raw > ONE_Q16) ? ONE_Q16 : sustain_raw;
  assign ad_end   = {1'b0, attack_len} + {1'b0, decay_len};
  assign t_plus_r = {1'b0, note_time} + {1'b0, release_len};

  always_comb begin
    seg     = ENV_ZERO;
    mul_a   = '0;
    mul_b   = '0;
    divisor = release_len;
    priority if (note_time < attack_len) begin
      seg     = ENV_ATTACK;
      mul_a   = ONE_Q16;
      mul_b   = note_time;
      divisor = attack_len;
    end else if ({1'b0, note_time} < ad_end) begin
      seg     = ENV_DECAY;
      mul_a   = ONE_Q16 - sustain;
      mul_b   = note_time - attack_len;
      divisor = decay_len;
    end else if (t_plus_r < {1'b0, note_len}) begin
      seg = ENV_SUSTAIN;
    end else if (release_len == '0 || note_time >= note_len) begin
      seg = ENV_ZERO;
    end else begin
      seg   = ENV_RELEASE;
      mul_a = sustain;
      mul_b = note_len - note_time;
    end
  end

  // Stage 1: phase product and dividend.
  logic [63:0]                phase_full;
  logic                       s1_valid;
  logic [1:0]                 s1_quad;
  logic [SINE_TABLE_BITS-1:0] s1_k;
  env_seg_t                   s1_seg;
  logic [DIVD_W-1:0]          s1_dividend;
  logic [TIME_W-1:0]          s1_divisor;
  logic [LEVEL_W-1:0]         s1_sustain;

  assign phase_full = phase_step * sample_index;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    s1_quad     <= phase_full[PHASE_BITS-1 -: 2];
    s1_k        <= phase_full[PHASE_BITS-3 -: SINE_TABLE_BITS];
    s1_seg      <= seg;
    s1_dividend <= mul_a * mul_b;
    s1_divisor  <= divisor;
    s1_sustain  <= sustain;
  end

  // Stage 2: quarter-wave table read.
  logic [LEVEL_W-1:0] sine_rom [0:N];
  logic [AW-1:0]      rom_addr;

  for (genvar g = 0; g <= N; g++) begin : g_rom
    assign sine_rom[g] = quarter_sine(longint'(g), SINE_TABLE_BITS);
  end

  assign rom_addr = s1_quad[0] ? (AW'(N) - {1'b0, s1_k}) : {1'b0, s1_k};

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else out_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    out_item.mag      <= sine_rom[rom_addr];
    out_item.neg      <= s1_quad[1];
    out_item.seg      <= s1_seg;
    out_item.dividend <= s1_dividend;
    out_item.divisor  <= s1_divisor;
    out_item.sustain  <= s1_sustain;
  end
endmodule

@@ hw/rtl/aesv_back.sv @@
// Back end: pipelined envelope divider and amplitude scaling.
module aesv_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  aesv_pkg::mid_item_t  in_item,
  output logic                 out_valid,
  output aesv_pkg::out_item_t  out_item
);
  import aesv_pkg::*;

  localparam int NS = QUOT_W;

  logic               v     [0:NS];
  logic [TIME_W-1:0]  rem   [0:NS];
  logic [QUOT_W-1:0]  low   [0:NS];
  logic [QUOT_W-1:0]  quot  [0:NS];
  logic [TIME_W-1:0]  dvs   [0:NS];
  env_seg_t           seg   [0:NS];
  logic [LEVEL_W-1:0] sus   [0:NS];
  logic [LEVEL_W-1:0] mag   [0:NS];
  logic               neg   [0:NS];

  assign v[0]    = in_valid;
  assign rem[0]  = in_item.dividend[DIVD_W-1 -: TIME_W];
  assign low[0]  = in_item.dividend[QUOT_W-1:0];
  assign quot[0] = '0;
  assign dvs[0]  = in_item.divisor;
  assign seg[0]  = in_item.seg;
  assign sus[0]  = in_item.sustain;
  assign mag[0]  = in_item.mag;
  assign neg[0]  = in_item.neg;

  // One restoring quotient bit per stage.
  for (genvar j = 0; j < NS; j++) begin : g_div
    logic [TIME_W:0] cand;
    logic [TIME_W:0] diff;
    logic            ge;
    assign cand = {rem[j], low[j][QUOT_W-1]};
    assign diff = cand - {1'b0, dvs[j]};
    assign ge   = (cand >= {1'b0, dvs[j]});

    always_ff @(posedge clk) begin
      if (rst) v[j+1] <= 1'b0;
      else v[j+1] <= v[j];
    end

    always_ff @(posedge clk) begin
      rem[j+1]  <= ge ? diff[TIME_W-1:0] : cand[TIME_W-1:0];
      low[j+1]  <= {low[j][QUOT_W-2:0], 1'b0};
      quot[j+1] <= {quot[j][QUOT_W-2:0], ge};
      dvs[j+1]  <= dvs[j];
      seg[j+1]  <= seg[j];
      sus[j+1]  <= sus[j];
      mag[j+1]  <= mag[j];
      neg[j+1]  <= neg[j];
    end
  end

  // Envelope finish.
  logic [LEVEL_W-1:0] env_c;
  logic               e_valid;
  logic [LEVEL_W-1:0] e_env;
  logic [LEVEL_W-1:0] e_mag;
  logic               e_neg;

  always_comb begin
    unique case (seg[NS])
      ENV_ATTACK:  env_c = quot[NS];
      ENV_DECAY:   env_c = ONE_Q16 - quot[NS];
      ENV_SUSTAIN: env_c = sus[NS];
      ENV_RELEASE: env_c = quot[NS];
      default:     env_c = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) e_valid <= 1'b0;
    else e_valid <= v[NS];
  end

  always_ff @(posedge clk) begin
    e_env <= env_c;
    e_mag <= mag[NS];
    e_neg <= neg[NS];
  end

  // Scale: envelope times sine, then times amplitude.
  logic                 m1_valid;
  logic [2*LEVEL_W-1:0] m1_prod;
  logic [LEVEL_W-1:0]   m1_env;
  logic                 m1_neg;
  logic                 m2_valid;
  logic [2*LEVEL_W+14:0] m2_prod;
  logic [LEVEL_W-1:0]   m2_env;
  logic                 m2_neg;
  logic [SAMPLE_W-1:0]  mag_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
      m2_valid <= 1'b0;
    end else begin
      m1_valid <= e_valid;
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    m1_prod <= e_env * e_mag;
    m1_env  <= e_env;
    m1_neg  <= e_neg;
    m2_prod <= m1_prod * AMPLITUDE;
    m2_env  <= m1_env;
    m2_neg  <= m1_neg;
  end

  assign mag_out         = {1'b0, m2_prod[46:32]};
  assign out_valid       = m2_valid;
  assign out_item.sample = m2_neg ? -mag_out : mag_out;
  assign out_item.level  = m2_env;
endmodule

@@ hw/rtl/adsr_envelope_sine_voice.sv @@
// Top level of the envelope-shaped sine voice.
// One voice sample per item: phase = phase_step * sample_index, sine from a quarter-wave
// table, scaled by 30000 and a piecewise-linear attack/decay/sustain/release envelope.
// The block takes one item every clock cycle when the result side keeps popping. An item
// passes the front end (phase multiply and segment decode, then table read), waits in a
// four-entry queue, then passes the back end (17-stage pipelined divider, envelope finish,
// two multiplier stages) before it shows up in the 32-entry result queue.
// full rises when the front pipe and the front-to-back queue together hold four items, and
// during reset; results stay until popped.
module adsr_envelope_sine_voice #(
  parameter int PHASE_BITS      = 32,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [aesv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aesv_pkg::CFG_DAT_W-1:0]     cfg_data,
  input  logic                               push,
  output logic                               full,
  input  logic [31:0]                        phase_step,
  input  logic [31:0]                        sample_index,
  input  logic [aesv_pkg::TIME_W-1:0]        note_time,
  output logic                               empty,
  input  logic                               pop,
  output logic signed [aesv_pkg::SAMPLE_W-1:0] sample,
  output logic [aesv_pkg::LEVEL_W-1:0]       envelope_level
);
  import aesv_pkg::*;

  localparam int MCW = $clog2(MID_DEPTH+1);
  localparam int OCW = $clog2(OUT_DEPTH+1);

  logic      accept;
  logic      front_valid;
  mid_item_t front_item;
  mid_item_t mid_head;
  logic      mid_empty;
  logic [MCW-1:0] mid_count;
  logic      mid_pop;
  logic      back_valid;
  out_item_t back_item;
  out_item_t out_head;
  logic [OCW-1:0] out_count;
  logic      out_pop;

  // Credits: items in the front pipe or in the middle queue.
  logic [MCW-1:0] mid_used;
  // Credits: items in the back pipe or in the result queue.
  logic [OCW-1:0] out_used;

  // Hold off input transfers while in reset, since the front pipe drops them there.
  assign cfg_ready = 1'b1;
  assign accept    = push && !full;
  assign full      = rst || (mid_used == MCW'(MID_DEPTH));
  assign mid_pop   = !mid_empty && (out_used != OCW'(OUT_DEPTH));
  assign out_pop   = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_used <= '0;
      out_used <= '0;
    end else begin
      if (accept && !mid_pop) mid_used <= mid_used + 1'b1;
      else if (mid_pop && !accept) mid_used <= mid_used - 1'b1;
      if (mid_pop && !out_pop) out_used <= out_used + 1'b1;
      else if (out_pop && !mid_pop) out_used <= out_used - 1'b1;
    end
  end

  aesv_front #(
    .PHASE_BITS      (PHASE_BITS),
    .SINE_TABLE_BITS (SINE_TABLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (accept),
    .phase_step   (phase_step),
    .sample_index (sample_index),
    .note_time    (note_time),
    .out_valid    (front_valid),
    .out_item     (front_item)
  );

  // Hold classified items until the back end has result room.
  aesv_queue #(
    .WIDTH ($bits(mid_item_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (front_valid),
    .wdata (front_item),
    .pop   (mid_pop),
    .rdata (mid_head),
    .empty (mid_empty),
    .count (mid_count)
  );

  aesv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mid_pop),
    .in_item   (mid_head),
    .out_valid (back_valid),
    .out_item  (back_item)
  );

  aesv_queue #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (back_valid),
    .wdata (back_item),
    .pop   (out_pop),
    .rdata (out_head),
    .empty (empty),
    .count (out_count)
  );

  assign sample         = out_head.sample;
  assign envelope_level = out_head.level;

  // The middle queue never holds more than the credits handed out.
  a_mid_credit: assert property (@(posedge clk) disable iff (rst)
    mid_count <= mid_used)
    else $error("middle queue holds more items than credited");

  // The result queue never takes a transfer while full.
  a_out_room: assert property (@(posedge clk) disable iff (rst)
    back_valid |-> (out_count < OCW'(OUT_DEPTH)))
    else $error("result queue overflow");

  // No outstanding back-end credits means nothing to pop.
  a_out_empty: assert property (@(posedge clk) disable iff (rst)
    (out_used == '0) |-> empty)
    else $error("result present without outstanding credit");

endmodule

@@ verif/tb.sv @@
// Testbench for adsr_envelope_sine_voice: self-checking stimulus, prediction and scoreboard.
`timescale 1ns / 1ps

module tb;
  import aesv_pkg::*;

  localparam int QTR_N   = 1024;
  localparam int HOLD_CY = 300;
  localparam int DRAIN_CY = 40;

  typedef struct {
    logic [31:0]       step;
    logic [31:0]       idx;
    logic [TIME_W-1:0] t;
  } voice_req_t;

  typedef struct {
    logic [SAMPLE_W-1:0] smp;
    logic [LEVEL_W-1:0]  lvl;
  } voice_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic push = 1'b0;
  logic full;
  logic [31:0] phase_step = '0;
  logic [31:0] sample_index = '0;
  logic [TIME_W-1:0] note_time = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic [LEVEL_W-1:0] envelope_level;

  // Shadow copy of the configuration registers.
  logic [TIME_W-1:0]  atk_len = 20'd441;
  logic [TIME_W-1:0]  dec_len = 20'd2205;
  logic [TIME_W-1:0]  rel_len = 20'd4410;
  logic [TIME_W-1:0]  note_len = 20'd22050;
  logic [LEVEL_W-1:0] sus_lvl = 17'd45875;

  logic [LEVEL_W-1:0] sine_qtr [0:QTR_N];

  voice_req_t voice_reqs[$];
  voice_out_t samples_due[$];
  int  mismatches = 0;
  bit  calm = 1'b0;
  bit  hold_req = 1'b0;

  adsr_envelope_sine_voice u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full),
    .phase_step(phase_step), .sample_index(sample_index), .note_time(note_time),
    .empty(empty), .pop(pop), .sample(sample), .envelope_level(envelope_level)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Quarter-wave sine entry in Q1.16 from an odd-power series on a Q30 angle.
  function automatic logic [LEVEL_W-1:0] sine_entry(input longint unsigned k);
    longint unsigned x, term, acc, r;
    bit minus;
    x = (k * 64'd1686629713) >> 10;
    term = x;
    acc = x;
    minus = 1'b1;
    for (int n = 1; n <= 7; n++) begin
      term = (((term * x) >> 30) * x) >> 30;
      term = term / ((2 * n) * (2 * n + 1));
      acc = minus ? acc - term : acc + term;
      minus = !minus;
    end
    r = (acc + 64'd8192) >> 14;
    if (r > 64'd65536) r = 64'd65536;
    return r[LEVEL_W-1:0];
  endfunction

  // Piecewise-linear envelope level at note time t.
  function automatic logic [LEVEL_W-1:0] envelope_at(input logic [TIME_W-1:0] tv);
    longint unsigned t, a, d, r, l, s, v;
    t = tv; a = atk_len; d = dec_len; r = rel_len; l = note_len;
    s = (sus_lvl > 17'h10000) ? 64'd65536 : longint'(sus_lvl);
    if (t < a) v = (t << 16) / a;
    else if (t < a + d) v = 64'd65536 - ((64'd65536 - s) * (t - a)) / d;
    else if (longint'(t) < longint'(l) - longint'(r)) v = s;
    else if (r == 0 || t >= l) v = 0;
    else v = (s * (l - t)) / r;
    return v[LEVEL_W-1:0];
  endfunction

  function automatic voice_out_t predict_voice(input voice_req_t q);
    voice_out_t o;
    logic [31:0] ph;
    logic [9:0] k;
    longint unsigned mag, env, prod;
    ph = q.step * q.idx;
    k = ph[29:20];
    mag = ph[30] ? sine_qtr[QTR_N - k] : sine_qtr[k];
    env = envelope_at(q.t);
    prod = (64'd30000 * env * mag) >> 32;
    if (ph[31]) prod = 64'd0 - prod;
    o.smp = prod[SAMPLE_W-1:0];
    o.lvl = env[LEVEL_W-1:0];
    return o;
  endfunction

  // Driver: offer pending items, with random gaps unless the run is in its calm tail.
  int tx_gap = 0;
  always @(posedge clk) begin : drv
    voice_req_t q;
    if (!rst) begin
      if (push && !full) begin
        q = voice_reqs.pop_front();
        samples_due.push_back(predict_voice(q));
      end
      if (tx_gap == 0 && !calm && $urandom_range(0, 7) == 0)
        tx_gap = $urandom_range(1, 8);
      if (tx_gap > 0 || voice_reqs.size() == 0) begin
        if (tx_gap > 0) tx_gap--;
        push <= 1'b0;
      end else begin
        q = voice_reqs[0];
        push <= 1'b1;
        phase_step <= q.step;
        sample_index <= q.idx;
        note_time <= q.t;
      end
    end
  end

  // Monitor: check each popped result against the oldest prediction.
  int rx_gap = 0;
  always @(posedge clk) begin : mon
    voice_out_t e;
    if (!rst) begin
      if (pop && !empty) begin
        if (samples_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: sample %0d level %0d", sample, envelope_level);
        end else begin
          e = samples_due.pop_front();
          if (sample !== e.smp || envelope_level !== e.lvl) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: sample exp %0d got %0d, level exp %0d got %0d",
                       $signed(e.smp), sample, e.lvl, envelope_level);
          end
        end
      end
      // A requested long hold-off starts here and is counted down locally.
      if (hold_req && rx_gap == 0) begin
        hold_req = 1'b0;
        rx_gap = HOLD_CY;
      end else if (rx_gap == 0 && !calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 8);
      end
      if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ATTACK:  atk_len = val;
      CFG_DECAY:   dec_len = val;
      CFG_RELEASE: rel_len = val;
      CFG_NOTE:    note_len = val;
      CFG_SUSTAIN: sus_lvl = val[LEVEL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_voice(input int a, input int d, input int r, input int l, input int s);
    cfg_write(CFG_ATTACK, CFG_DAT_W'(a));
    cfg_write(CFG_DECAY, CFG_DAT_W'(d));
    cfg_write(CFG_RELEASE, CFG_DAT_W'(r));
    cfg_write(CFG_NOTE, CFG_DAT_W'(l));
    cfg_write(CFG_SUSTAIN, CFG_DAT_W'(s));
    // Unmapped indexes must leave everything alone.
    cfg_write(CFG_IDX_W'($urandom_range(5, 7)), CFG_DAT_W'($urandom));
  endtask

  task automatic queue_item(input logic [31:0] st, input logic [31:0] ix, input int t);
    voice_req_t q;
    q.step = st;
    q.idx = ix;
    q.t = TIME_W'(t);
    voice_reqs.push_back(q);
  endtask

  // Pick a note time: a segment edge or a small base plus a small or a random offset, or any value.
  function automatic int pick_time();
    int base, off;
    off = $urandom_range(0, 16) - 8;
    case ($urandom_range(0, 5))
      0: base = int'(atk_len);
      1: base = int'(atk_len) + int'(dec_len);
      2: base = int'(note_len) - int'(rel_len);
      3: base = int'(note_len);
      4: base = $urandom_range(0, 64);
      default: return $urandom_range(0, 20'hFFFFF);
    endcase
    if ($urandom_range(0, 1)) off = $urandom_range(0, 20'hFFFFF) % (int'(note_len) + 1);
    return (base + off) & 20'hFFFFF;
  endfunction

  task automatic queue_random(input int n);
    logic [31:0] st;
    repeat (n) begin
      st = $urandom;
      if ($urandom_range(0, 3) == 0) st = $urandom_range(0, 2000);
      queue_item(st, $urandom, pick_time());
    end
  endtask

  // Hold off until every queued item has been sent and every result has come back.
  task automatic drain();
    while (voice_reqs.size() != 0 || samples_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CY) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i <= QTR_N; i++) sine_qtr[i] = sine_entry(i);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, all quadrants, table ends, segment edges at reset config.
    queue_item(32'd0, 32'd0, 0);
    queue_item(32'hFFFFFFFF, 32'hFFFFFFFF, 20'hFFFFF);
    queue_item(32'h40000000, 32'd1, 440);
    queue_item(32'h40000000, 32'd2, 441);
    queue_item(32'h40000000, 32'd3, 2645);
    queue_item(32'h40000000, 32'd4, 2644);
    queue_item(32'h3FF00000, 32'd1, 17639);
    queue_item(32'h00100000, 32'd1, 17640);
    queue_item(32'h7FF00000, 32'd1, 22049);
    queue_item(32'hBFF00000, 32'd1, 22050);
    queue_item(32'hFFF00000, 32'd1, 30000);
    queue_item(32'hFFFFFFFF, 32'd1, 1000);
    queue_item(32'd1, 32'hFFFFFFFF, 5000);
    queue_item(32'h55555555, 32'hAAAAAAAA, 20'h55555);
    queue_item(32'hAAAAAAAA, 32'h55555555, 20'hAAAAA);
    queue_random(200);
    drain();

    // All registers at their minimum: every segment collapses to zero.
    set_voice(0, 0, 0, 0, 0);
    queue_random(150);
    queue_item(32'h40000000, 32'd1, 0);
    drain();

    // All at maximum, sustain written above full scale; receiver holds off for a while.
    set_voice(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    @(negedge clk);
    hold_req = 1'b1;
    queue_random(200);
    drain();

    // Release begins before decay ends.
    set_voice(1000, 5000, 10000, 8000, 30000);
    queue_random(200);
    drain();

    // Zero release length, full sustain.
    set_voice(50, 80, 0, 600, 65536);
    queue_random(200);
    drain();

    repeat (3) begin
      set_voice($urandom_range(0, 4000), $urandom_range(0, 4000), $urandom_range(0, 4000),
                $urandom_range(0, 12000), $urandom_range(0, 65536));
      queue_random(200);
      drain();
    end

    // Calm tail: no gaps on either side.
    set_voice($urandom_range(1, 300), $urandom_range(1, 300), $urandom_range(1, 300),
              $urandom_range(0, 2000), $urandom_range(0, 20'hFFFFF));
    calm = 1'b1;
    queue_random(250);
    drain();

    if (mismatches == 0 && samples_due.size() == 0) begin
      $display("adsr_envelope_sine_voice regression: pass");
    end else begin
      $display("adsr_envelope_sine_voice regression: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("adsr_envelope_sine_voice regression: fail");
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/aesv_pkg.sv
hw/rtl/aesv_queue.sv
hw/rtl/aesv_front.sv
hw/rtl/aesv_back.sv
hw/rtl/adsr_envelope_sine_voice.sv
verif/tb.sv
